>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the hash map RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define CHM_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CHM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Types and fixed widths shared by the hash map modules.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 32;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_FIND   = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HEAD,
    ST_WALK
  } back_state_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] found_value;
    logic             full_res;
  } result_t;

endpackage

>>> rtl/chm_fifo.sv
// ----------------------------------------------------------------------------
// chm_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chm_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CHM_ASSERT(a_fifo_no_overflow, clk, rst, !(push && full), "chm_fifo: push while full")
  `CHM_ASSERT(a_fifo_count_bounded, clk, rst, count <= CNT_W'(DEPTH), "chm_fifo: count above depth")
  `CHM_ASSERT_NXT(a_fifo_push_fills, clk, rst, do_push && !do_pop, !empty, "chm_fifo: empty after push")

endmodule

>>> rtl/chm_front.sv
// ----------------------------------------------------------------------------
// chm_front
// Accepts items and computes the bucket index as key modulo the bucket count
// with a two-stage reciprocal multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module chm_front #(
  parameter int unsigned CAPACITY      = 1024,
  parameter int unsigned BUCKET_FACTOR = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        func,
  input  logic [chm_pkg::KEY_W-1:0]   key,
  input  logic [chm_pkg::VAL_W-1:0]   entry_value,
  output logic                        mq_push,
  output logic [chm_pkg::KEY_W+chm_pkg::VAL_W+$clog2(CAPACITY*BUCKET_FACTOR):0] mq_data,
  input  logic                        mq_full
);

  import chm_pkg::*;

  localparam int unsigned NUM_BUCKETS = CAPACITY * BUCKET_FACTOR;
  localparam int unsigned BKT_W       = $clog2(NUM_BUCKETS);
  localparam int unsigned PROD_W      = 2 * KEY_W;
  localparam logic [KEY_W-1:0] NB_K   = KEY_W'(NUM_BUCKETS);
  localparam logic [KEY_W-1:0] RECIP  = KEY_W'((64'd1 << KEY_W) / NUM_BUCKETS);

  logic              en;
  logic              v1;
  logic              f1;
  logic [KEY_W-1:0]  k1;
  logic [VAL_W-1:0]  val1;
  logic [PROD_W-1:0] prod1;
  logic              v2;
  logic              f2;
  logic [KEY_W-1:0]  k2;
  logic [VAL_W-1:0]  val2;
  logic [KEY_W-1:0]  qn2;
  logic [KEY_W-1:0]  q_est;
  logic [KEY_W-1:0]  rem_raw;
  logic [KEY_W-1:0]  rem_fix;

  assign en    = !(v2 && mq_full);
  assign full  = !en;
  assign q_est = prod1[PROD_W-1 -: KEY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= func;
      k1    <= key;
      val1  <= entry_value;
      prod1 <= PROD_W'(key) * PROD_W'(RECIP);
      f2    <= f1;
      k2    <= k1;
      val2  <= val1;
      qn2   <= q_est * NB_K;
    end
  end

  // The quotient estimate is low by at most one, so the raw remainder stays
  // below twice the bucket count.
  assign rem_raw = k2 - qn2;
  assign rem_fix = (rem_raw >= NB_K) ? rem_raw - NB_K : rem_raw;

  assign mq_push = v2 && !mq_full;
  assign mq_data = {f2, k2, val2, rem_fix[BKT_W-1:0]};

endmodule

>>> rtl/chm_back.sv
// ----------------------------------------------------------------------------
// chm_back
// Carries out inserts and finds on the bucket head and entry pool memories.
// Clears every bucket head after reset before taking the first item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chm_back #(
  parameter int unsigned CAPACITY      = 1024,
  parameter int unsigned BUCKET_FACTOR = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [chm_pkg::KEY_W+chm_pkg::VAL_W+$clog2(CAPACITY*BUCKET_FACTOR):0] q_data,
  output logic                        q_pop,
  output logic                        res_push,
  output chm_pkg::result_t            res,
  input  logic                        res_full,
  output logic                        clearing
);

  import chm_pkg::*;

  localparam int unsigned NUM_BUCKETS = CAPACITY * BUCKET_FACTOR;
  localparam int unsigned BKT_W       = $clog2(NUM_BUCKETS);
  localparam int unsigned IDX_W       = $clog2(CAPACITY + 1);
  localparam int unsigned PTR_W       = $clog2(CAPACITY);
  localparam int unsigned ENT_W       = KEY_W + VAL_W + IDX_W;
  localparam logic [IDX_W-1:0] EMPTY  = IDX_W'(CAPACITY);

  logic [IDX_W-1:0] head_mem  [NUM_BUCKETS];
  logic [ENT_W-1:0] entry_mem [CAPACITY];

  back_state_t      state;
  back_state_t      state_next;
  logic [IDX_W-1:0] used;
  logic [BKT_W-1:0] clr_cnt;
  func_t            cur_func;
  logic [KEY_W-1:0] cur_key;
  logic [VAL_W-1:0] cur_val;
  logic [BKT_W-1:0] cur_bkt;
  logic [IDX_W-1:0] head_rd;
  logic [ENT_W-1:0] entry_rd;

  logic [BKT_W-1:0] q_bkt;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [IDX_W-1:0] rd_next;
  logic             start;
  logic             pool_full;
  logic             hit;
  logic             clr_last;

  logic             head_re;
  logic             head_we;
  logic [BKT_W-1:0] head_waddr;
  logic [IDX_W-1:0] head_wdata;
  logic             entry_we;
  logic             entry_re;
  logic [PTR_W-1:0] entry_raddr;

  assign q_bkt     = q_data[BKT_W-1:0];
  assign rd_key    = entry_rd[ENT_W-1 -: KEY_W];
  assign rd_val    = entry_rd[IDX_W +: VAL_W];
  assign rd_next   = entry_rd[IDX_W-1:0];
  assign start     = !q_empty && !res_full;
  assign pool_full = (used == EMPTY);
  assign hit       = (rd_key == cur_key);
  assign clr_last  = (clr_cnt == BKT_W'(NUM_BUCKETS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (cur_func == FUNC_FIND && head_rd != EMPTY) begin
          state_next = ST_WALK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (hit || rd_next == EMPTY) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    head_re     = 1'b0;
    head_we     = 1'b0;
    head_waddr  = cur_bkt;
    head_wdata  = used;
    entry_we    = 1'b0;
    entry_re    = 1'b0;
    entry_raddr = head_rd[PTR_W-1:0];
    res_push    = 1'b0;
    res         = '0;
    clearing    = 1'b0;
    case (state)
      ST_CLEAR: begin
        clearing   = 1'b1;
        head_we    = 1'b1;
        head_waddr = clr_cnt;
        head_wdata = EMPTY;
      end
      ST_IDLE: begin
        if (start) begin
          q_pop   = 1'b1;
          head_re = 1'b1;
        end
      end
      ST_HEAD: begin
        if (cur_func == FUNC_INSERT) begin
          res_push = 1'b1;
          if (pool_full) begin
            res.full_res = 1'b1;
          end else begin
            head_we  = 1'b1;
            entry_we = 1'b1;
          end
        end else if (head_rd == EMPTY) begin
          res_push = 1'b1;
        end else begin
          entry_re = 1'b1;
        end
      end
      ST_WALK: begin
        if (hit) begin
          res_push          = 1'b1;
          res.found         = 1'b1;
          res.found_value   = rd_val;
        end else if (rd_next == EMPTY) begin
          res_push = 1'b1;
        end else begin
          entry_re    = 1'b1;
          entry_raddr = rd_next[PTR_W-1:0];
        end
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      used    <= '0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (entry_we) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_func <= func_t'(q_data[KEY_W+VAL_W+BKT_W]);
      cur_key  <= q_data[BKT_W+VAL_W +: KEY_W];
      cur_val  <= q_data[BKT_W +: VAL_W];
      cur_bkt  <= q_bkt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd <= head_mem[q_bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[used[PTR_W-1:0]] <= {cur_key, cur_val, head_rd};
    end
    if (entry_re) begin
      entry_rd <= entry_mem[entry_raddr];
    end
  end

  `CHM_ASSERT(a_used_bounded, clk, rst, used <= EMPTY, "chm_back: pool count above capacity")
  `CHM_ASSERT_IMP(a_full_drops, clk, rst, state == ST_HEAD && cur_func == FUNC_INSERT && pool_full,
    !entry_we && !head_we && res_push && res.full_res, "chm_back: insert into full pool not dropped")
  `CHM_ASSERT_IMP(a_res_space, clk, rst, res_push, !res_full, "chm_back: result with no space")
  `CHM_ASSERT_NXT(a_used_step, clk, rst, entry_we, used == $past(used) + 1'b1,
    "chm_back: pool count did not advance on insert")

endmodule

>>> rtl/chained_hash_map.sv
// ----------------------------------------------------------------------------
// chained_hash_map
// Key/value hash table with separate chaining and a fixed entry pool.
//
//   Channel  Handshake     Fields
//   input    push / full   func, key, entry_value
//   result   empty / pop   found, found_value, full_res
//
// The front takes an item per cycle unless a full mid queue stalls it; an
// insert then takes the back through IDLE and HEAD, and a find goes on to
// WALK, which does one entry memory read per chain entry that it visits.
// After reset the back clears all CAPACITY*BUCKET_FACTOR bucket heads, one per
// cycle, and full stays high for that pass.
// A 4-deep queue lets the front run ahead while the back walks a chain.
// ----------------------------------------------------------------------------
module chained_hash_map #(
  parameter int unsigned CAPACITY      = 1024,
  parameter int unsigned BUCKET_FACTOR = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      func,
  input  logic [chm_pkg::KEY_W-1:0] key,
  input  logic [chm_pkg::VAL_W-1:0] entry_value,
  output logic                      empty,
  input  logic                      pop,
  output logic                      found,
  output logic [chm_pkg::VAL_W-1:0] found_value,
  output logic                      full_res
);

  import chm_pkg::*;

  localparam int unsigned BKT_W  = $clog2(CAPACITY * BUCKET_FACTOR);
  localparam int unsigned ITEM_W = 1 + KEY_W + VAL_W + BKT_W;
  localparam int unsigned RES_W  = $bits(result_t);

  logic              clearing;
  logic              fe_push;
  logic              fe_full;
  logic              mq_push;
  logic              mq_full;
  logic              mq_empty;
  logic              mq_pop;
  logic [ITEM_W-1:0] mq_wdata;
  logic [ITEM_W-1:0] mq_rdata;
  logic              res_push;
  logic              res_full;
  result_t           res_in;
  logic [RES_W-1:0]  res_rdata;
  result_t           res_out;

  assign fe_push = push && !clearing;
  assign full    = fe_full || clearing;

  chm_front #(
    .CAPACITY      (CAPACITY),
    .BUCKET_FACTOR (BUCKET_FACTOR)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (fe_push),
    .full        (fe_full),
    .func        (func),
    .key         (key),
    .entry_value (entry_value),
    .mq_push     (mq_push),
    .mq_data     (mq_wdata),
    .mq_full     (mq_full)
  );

  chm_fifo #(
    .DEPTH (4),
    .WIDTH (ITEM_W)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  chm_back #(
    .CAPACITY      (CAPACITY),
    .BUCKET_FACTOR (BUCKET_FACTOR)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (mq_empty),
    .q_data   (mq_rdata),
    .q_pop    (mq_pop),
    .res_push (res_push),
    .res      (res_in),
    .res_full (res_full),
    .clearing (clearing)
  );

  chm_fifo #(
    .DEPTH (2),
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out     = result_t'(res_rdata);
  assign found       = res_out.found;
  assign found_value = res_out.found_value;
  assign full_res    = res_out.full_res;

endmodule
